FILE: design/gmbs_pkg.sv
package gmbs_pkg;

  // Field widths
  localparam int LOC_W      = 14;
  localparam int CH_W       = 2;
  localparam int SAMPLE_W   = 8;
  localparam int MEAN_W     = 16;
  localparam int VAR_W      = 24;
  localparam int WGT_W      = 16;
  localparam int RATE_W     = 16;
  localparam int COMP_W     = MEAN_W + VAR_W + WGT_W;
  localparam int SUM_W      = 19;
  localparam int QUOT_W     = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Arithmetic constants
  localparam logic [10:0]         MATCH_SCALE = 11'd1600;
  localparam logic [SAMPLE_W-1:0] FG_VALUE    = 8'hFF;
  localparam int                  INIT_MEAN_BASE = 50;
  localparam int                  INIT_MEAN_STEP = 80;

  // Register reset values
  localparam logic [RATE_W-1:0] WEIGHT_RATE_RST = 16'd655;
  localparam logic [RATE_W-1:0] MODEL_RATE_RST  = 16'd655;
  localparam logic [WGT_W-1:0]  BG_SHARE_RST    = 16'd58982;
  localparam logic [VAR_W-1:0]  REPLACE_VAR_RST = 24'd2560000;
  localparam logic [VAR_W-1:0]  INIT_VAR_RST    = 24'd2560000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_RATE = 3'd0,
    CFG_MODEL_RATE  = 3'd1,
    CFG_BG_SHARE    = 3'd2,
    CFG_REPLACE_VAR = 3'd3,
    CFG_INIT_VAR    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [QUOT_W-1:0] dividend;
    logic [SUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  // Mean loaded by an init word for component g, Q8.8
  function automatic logic [MEAN_W-1:0] init_mean(input int g);
    int mu;
    mu = INIT_MEAN_BASE + INIT_MEAN_STEP * g;
    if (mu > 255) mu = 255;
    return {8'(mu), 8'h00};
  endfunction

endpackage

FILE: design/gmbs_if.sv
interface gmbs_in_if;
  import gmbs_pkg::*;
  logic                valid;
  logic                ready;
  logic [LOC_W-1:0]    location;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;
  logic                init_model;
  modport source(output valid, location, channel, sample, init_model, input ready);
  modport sink(input valid, location, channel, sample, init_model, output ready);
endinterface

interface gmbs_out_if;
  import gmbs_pkg::*;
  logic                valid;
  logic                ready;
  logic                foreground;
  logic [SAMPLE_W-1:0] out_value;
  logic                replaced;
  modport source(output valid, foreground, out_value, replaced, input ready);
  modport sink(input valid, foreground, out_value, replaced, output ready);
endinterface

FILE: design/gaussian_mixture_background_subtract_core.sv
// Per-pixel mixture-of-Gaussians background subtractor. Each word carries one
// 8-bit sample of one channel at one location; the block reads that
// location/channel row (all components) from an on-chip memory, updates the
// means, variances and weights, renormalizes, ranks and writes the row back,
// then returns one result word (foreground flag, value, replacement flag).
// One word is in flight at a time, so a row is always written before the next
// read and no forwarding is needed. A word's result becomes valid in the same
// cycle as the block is ready to take the next word. The location modulo is
// computed in S_MOD and S_MODR; each component then passes through the
// five-step update, then (unless the weights sum to zero) each through the
// 33-step restoring divider used for renormalization, and the row is ranked
// by odd-even passes, each a cross-product step (S_SORTM) and a swap step
// (S_SORTS). A word whose channel is out of range skips the memory and returns
// its result from S_BAD once the output register is free. Memory contents are
// undefined until a location/channel has seen a word with init_model set.
module gaussian_mixture_background_subtract_core #(
  parameter int LOCATIONS  = 16384,
  parameter int COMPONENTS = 3,
  parameter int CHANNELS   = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  gmbs_in_if.sink                             in_ch,
  gmbs_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [gmbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gmbs_pkg::*;

  localparam int ROWS  = LOCATIONS * CHANNELS;
  localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RW    = $clog2(LOCATIONS) + 1;
  localparam int ROW_W = COMP_W * COMPONENTS;
  localparam int GW    = $clog2(COMPONENTS + 1);
  localparam logic [WGT_W-1:0] INIT_WGT  = WGT_W'(65536 / COMPONENTS);
  localparam logic [32:0]      LOC_RECIP = 33'((64'd1 << 32) / LOCATIONS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BAD, S_MOD, S_MODR, S_RD, S_LOAD, S_UPD, S_DIVCHK, S_DIVGO,
    S_DIVWAIT, S_SORTM, S_SORTS, S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [RATE_W-1:0] weight_rate_r, model_rate_r;
  logic [WGT_W-1:0]  bg_share_r;
  logic [VAR_W-1:0]  replace_var_r, init_var_r;

  // Word registers
  logic [LOC_W-1:0]    loc_r;
  logic [CH_W-1:0]     ch_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic                init_r;
  logic [RW-1:0]       rem_r;
  logic [LOC_W-1:0]    locq_r;

  // Working row
  logic [MEAN_W-1:0] m_r [COMPONENTS];
  logic [VAR_W-1:0]  v_r [COMPONENTS];
  logic [WGT_W-1:0]  w_r [COMPONENTS];
  logic              hit_r [COMPONENTS];
  logic [GW-1:0]     g_r;
  logic [GW-1:0]     pass_r;
  logic [2:0]        step_r;
  logic [SUM_W-1:0]  sum_r;
  logic              any_r;
  logic [31:0]       d2_r;
  logic [34:0]       vm_r;
  logic              hcur_r;
  logic [MEAN_W-1:0] mnew_r;
  logic [VAR_W-1:0]  e_r;
  logic [VAR_W-1:0]  vnew_r;
  logic [39:0]       pa_r [COMPONENTS-1];
  logic [39:0]       pb_r [COMPONENTS-1];

  // Result registers
  logic                out_valid_r, fg_r, repl_r;
  logic [SAMPLE_W-1:0] oval_r;

  // Memory and divider hookup
  logic             rd_en, wr_en;
  logic [AW-1:0]    row_addr;
  logic [ROW_W-1:0] rd_data, wr_data;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Datapath signals
  logic [MEAN_W-1:0]        x;
  logic                     out_free;
  logic [LOC_W+32:0]        loc_prod;
  logic signed [16:0]       diff0, diff2;
  logic [15:0]              ad0, ad2;
  logic signed [33:0]       macc;
  logic [31:0]              sq2;
  logic signed [24:0]       dv;
  logic signed [42:0]       vacc;
  logic signed [17:0]       wt_t;
  logic signed [34:0]       wacc;
  logic [WGT_W-1:0]         wres;
  logic [WGT_W-1:0]         qsat;
  logic [SUM_W-1:0]         cum;
  logic                     found, fg_c;
  logic [MEAN_W-1:0]        m_fin [COMPONENTS];
  logic [VAR_W-1:0]         v_fin [COMPONENTS];

  assign x        = {smp_r, 8'h00};
  assign out_free = !out_valid_r || out_ch.ready;

  // Location modulo by reciprocal multiplication
  assign loc_prod = loc_r * LOC_RECIP;

  // Update arithmetic on component 0 of the rotating row
  always_comb begin
    diff0 = $signed({1'b0, x}) - $signed({1'b0, m_r[0]});
    ad0   = diff0[16] ? 16'(-diff0) : diff0[15:0];
    macc  = $signed({2'b00, m_r[0], 16'h0000})
          + 34'(diff0 * $signed({1'b0, model_rate_r}))
          + 34'sd32768;
    diff2 = $signed({1'b0, x}) - $signed({1'b0, mnew_r});
    ad2   = diff2[16] ? 16'(-diff2) : diff2[15:0];
    sq2   = (ad2 * ad2) + 32'd128;
    dv    = $signed({1'b0, e_r}) - $signed({1'b0, v_r[0]});
    vacc  = $signed({3'b000, v_r[0], 16'h0000})
          + 43'(dv * $signed({1'b0, model_rate_r}))
          + 43'sd32768;
    wt_t  = hcur_r ? (18'sd65536 - $signed({2'b00, w_r[0]}))
                   : -$signed({2'b00, w_r[0]});
    wacc  = $signed({3'b000, w_r[0], 16'h0000})
          + 35'(wt_t * $signed({1'b0, weight_rate_r}))
          + 35'sd32768;
    wres  = (wacc[34:16] > 19'h0FFFF) ? 16'hFFFF : wacc[31:16];
    qsat  = (div_rsp.quot > 33'h0FFFF) ? 16'hFFFF : div_rsp.quot[15:0];
  end

  // Background set, foreground decision and replacement
  always_comb begin
    cum   = '0;
    found = 1'b0;
    fg_c  = 1'b1;
    for (int g = 0; g < COMPONENTS; g++) begin
      if (!found && hit_r[g]) fg_c = 1'b0;
      cum = cum + SUM_W'(w_r[g]);
      if (cum > SUM_W'(bg_share_r)) found = 1'b1;
      m_fin[g] = m_r[g];
      v_fin[g] = v_r[g];
    end
    if (!any_r) begin
      m_fin[COMPONENTS-1] = x;
      v_fin[COMPONENTS-1] = replace_var_r;
    end
    for (int g = 0; g < COMPONENTS; g++) begin
      wr_data[g*COMP_W +: COMP_W] = {w_r[g], v_fin[g], m_fin[g]};
    end
  end

  assign rd_en    = (state_r == S_RD);
  assign wr_en    = (state_r == S_FIN) && out_free;
  assign row_addr = AW'(rem_r * CHANNELS + ch_r);

  assign div_req.start    = (state_r == S_DIVGO);
  assign div_req.dividend = {1'b0, w_r[0], 16'h0000} + QUOT_W'(sum_r >> 1);
  assign div_req.divisor  = sum_r;

  gmbs_mem #(.DEPTH(ROWS), .AW(AW), .DW(ROW_W)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (row_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (row_addr),
    .wr_data (wr_data)
  );

  gmbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_rate_r <= WEIGHT_RATE_RST;
      model_rate_r  <= MODEL_RATE_RST;
      bg_share_r    <= BG_SHARE_RST;
      replace_var_r <= REPLACE_VAR_RST;
      init_var_r    <= INIT_VAR_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WEIGHT_RATE: weight_rate_r <= cfg_wdata[RATE_W-1:0];
        CFG_MODEL_RATE:  model_rate_r  <= cfg_wdata[RATE_W-1:0];
        CFG_BG_SHARE:    bg_share_r    <= cfg_wdata[WGT_W-1:0];
        CFG_REPLACE_VAR: replace_var_r <= cfg_wdata[VAR_W-1:0];
        CFG_INIT_VAR:    init_var_r    <= cfg_wdata[VAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, working row and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            loc_r  <= in_ch.location;
            ch_r   <= in_ch.channel;
            smp_r  <= in_ch.sample;
            init_r <= in_ch.init_model;
            state_r <= (int'(in_ch.channel) >= CHANNELS) ? S_BAD : S_MOD;
          end
        end
        S_BAD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            fg_r        <= 1'b1;
            oval_r      <= FG_VALUE;
            repl_r      <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_MOD: begin
          // quotient of the location by the location count
          locq_r  <= loc_prod[LOC_W+31:32];
          state_r <= S_MODR;
        end
        S_MODR: begin
          rem_r   <= RW'(loc_r - LOC_W'(locq_r * LOCATIONS));
          state_r <= S_RD;
        end
        S_RD: state_r <= S_LOAD;
        S_LOAD: begin
          for (int g = 0; g < COMPONENTS; g++) begin
            m_r[g] <= init_r ? init_mean(g) : rd_data[g*COMP_W +: MEAN_W];
            v_r[g] <= init_r ? init_var_r : rd_data[g*COMP_W + MEAN_W +: VAR_W];
            w_r[g] <= init_r ? INIT_WGT : rd_data[g*COMP_W + MEAN_W + VAR_W +: WGT_W];
          end
          sum_r   <= '0;
          any_r   <= 1'b0;
          g_r     <= '0;
          step_r  <= '0;
          state_r <= S_UPD;
        end
        S_UPD: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd0: begin
              d2_r <= ad0 * ad0;
              vm_r <= v_r[0] * MATCH_SCALE;
            end
            3'd1: begin
              hcur_r <= ({3'b000, d2_r} < vm_r);
              mnew_r <= macc[31:16];
            end
            3'd2: e_r <= sq2[31:8];
            3'd3: vnew_r <= (vacc[42:16] > 27'hFFFFFF) ? 24'hFFFFFF : vacc[39:16];
            default: begin
              // write back component 0 and rotate the row
              for (int g = 0; g < COMPONENTS - 1; g++) begin
                m_r[g]   <= m_r[g+1];
                v_r[g]   <= v_r[g+1];
                w_r[g]   <= w_r[g+1];
                hit_r[g] <= hit_r[g+1];
              end
              m_r[COMPONENTS-1]   <= hcur_r ? mnew_r : m_r[0];
              v_r[COMPONENTS-1]   <= hcur_r ? vnew_r : v_r[0];
              w_r[COMPONENTS-1]   <= wres;
              hit_r[COMPONENTS-1] <= hcur_r;
              sum_r  <= sum_r + SUM_W'(wres);
              any_r  <= any_r | hcur_r;
              step_r <= '0;
              g_r    <= g_r + GW'(1);
              if (g_r == GW'(COMPONENTS - 1)) state_r <= S_DIVCHK;
            end
          endcase
        end
        S_DIVCHK: begin
          g_r     <= '0;
          pass_r  <= '0;
          state_r <= (sum_r == '0) ? S_SORTM : S_DIVGO;
        end
        S_DIVGO: state_r <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (div_rsp.done) begin
            // store normalized weight and rotate
            for (int g = 0; g < COMPONENTS - 1; g++) begin
              m_r[g]   <= m_r[g+1];
              v_r[g]   <= v_r[g+1];
              w_r[g]   <= w_r[g+1];
              hit_r[g] <= hit_r[g+1];
            end
            m_r[COMPONENTS-1]   <= m_r[0];
            v_r[COMPONENTS-1]   <= v_r[0];
            w_r[COMPONENTS-1]   <= qsat;
            hit_r[COMPONENTS-1] <= hit_r[0];
            g_r <= g_r + GW'(1);
            state_r <= (g_r == GW'(COMPONENTS - 1)) ? S_SORTM : S_DIVGO;
          end
        end
        S_SORTM: begin
          // cross products of neighbors
          for (int k = 0; k < COMPONENTS - 1; k++) begin
            pa_r[k] <= w_r[k+1] * v_r[k];
            pb_r[k] <= w_r[k] * v_r[k+1];
          end
          state_r <= S_SORTS;
        end
        S_SORTS: begin
          // swap neighbors of this pass's parity when the later ranks above
          for (int k = 0; k < COMPONENTS - 1; k++) begin
            if ((k % 2) == int'(pass_r[0]) && pa_r[k] > pb_r[k]) begin
              m_r[k]     <= m_r[k+1];
              m_r[k+1]   <= m_r[k];
              v_r[k]     <= v_r[k+1];
              v_r[k+1]   <= v_r[k];
              w_r[k]     <= w_r[k+1];
              w_r[k+1]   <= w_r[k];
              hit_r[k]   <= hit_r[k+1];
              hit_r[k+1] <= hit_r[k];
            end
          end
          pass_r  <= pass_r + GW'(1);
          state_r <= (pass_r == GW'(COMPONENTS - 1)) ? S_FIN : S_SORTM;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            fg_r        <= fg_c;
            oval_r      <= fg_c ? FG_VALUE : smp_r;
            repl_r      <= !any_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.foreground = fg_r;
  assign out_ch.out_value  = oval_r;
  assign out_ch.replaced   = repl_r;

endmodule

FILE: design/gmbs_mem.sv
module gmbs_mem #(
  parameter int DEPTH = 49152,
  parameter int AW    = 16,
  parameter int DW    = 168
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: design/gmbs_div.sv
module gmbs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gmbs_pkg::div_req_t  req,
  output gmbs_pkg::div_rsp_t  rsp
);
  import gmbs_pkg::*;

  logic                busy_r;
  logic [5:0]          cnt_r;
  logic [SUM_W-1:0]    rem_r;
  logic [QUOT_W-1:0]   quo_r;
  logic [SUM_W-1:0]    divisor_r;
  logic                done_r;
  logic [SUM_W:0]      trial;
  logic                take;

  // One restoring step: shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, quo_r[QUOT_W-1]};
    take  = (trial >= {1'b0, divisor_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r    <= 1'b1;
        cnt_r     <= 6'(QUOT_W - 1);
        rem_r     <= '0;
        quo_r     <= req.dividend;
        divisor_r <= req.divisor;
      end else if (busy_r) begin
        rem_r <= take ? SUM_W'(trial - {1'b0, divisor_r}) : trial[SUM_W-1:0];
        quo_r <= {quo_r[QUOT_W-2:0], take};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

FILE: design/gmbs_checker.sv
module gmbs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       foreground,
  input logic [7:0] out_value,
  input logic       replaced
);

  // Hold a result until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A replacement means nothing matched, so the sample is foreground
  a_repl_fg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && replaced |-> foreground)
    else $error("replaced word not marked foreground");

  // Foreground words carry the full-scale value
  a_fg_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && foreground |-> out_value == 8'hFF)
    else $error("foreground word with wrong value");

  // One word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // Reset empties the result register
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gaussian_mixture_background_subtract_core gmbs_checker u_gmbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .foreground (out_ch.foreground),
  .out_value  (out_ch.out_value),
  .replaced   (out_ch.replaced)
);
